>>> design/uart_rx_pkg.sv
package uart_rx_pkg;

   localparam int FIFO_DEPTH = 64;
   localparam int PTR_W      = $clog2(FIFO_DEPTH);
   localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);
   localparam int DATA_BITS  = 8;
   localparam int IDX_W      = $clog2(DATA_BITS);
   localparam int PERIOD_W   = 16;

   localparam logic [PERIOD_W-1:0] PERIOD_RESET = PERIOD_W'(1667);

   typedef struct packed {
      logic rx_level;
      logic pop_request;
   } uart_rx_req_type;

   typedef struct packed {
      logic                 pop_valid;
      logic [DATA_BITS-1:0] pop_byte;
      logic [CNT_W-1:0]     bytes_available;
      logic                 overflow;
      logic                 receiving;
   } uart_rx_rsp_type;

   // per-beat status from the framer to the FIFO control
   typedef struct packed {
      logic                 have_byte;
      logic [DATA_BITS-1:0] new_byte;
      logic                 busy;
   } uart_rx_frm_type;

endpackage

>>> design/uart_8n1_receiver_with_fifo.sv
// UART 8N1 receiver with a 64-byte receive FIFO. Each input beat is one line
// sample plus a pop request and yields exactly one response beat. A beat is
// registered on entry, stepped combinationally through the framer and FIFO
// control, and lands in the output register, so one beat per cycle is sustained
// while rsp_stall is low; the popped byte comes from the FIFO RAM's registered
// read port. On a low line the framer waits half of csr bit_period beats, takes
// 8 data bits LSB first one period apart, pushes the byte and then waits one
// more period (stop bit is not checked). A byte arriving while the FIFO is full
// with no pop on that beat is dropped and flagged by overflow. Write bit_period
// only while no beat is in flight; it applies from the next beat, also in mid-frame.
module uart_8n1_receiver_with_fifo import uart_rx_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  uart_rx_req_type     req_payload,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output uart_rx_rsp_type     rsp_payload,
   input  logic                csr_write,
   input  logic [PERIOD_W-1:0] csr_data
);

   logic [PERIOD_W-1:0] bit_period_ff;
   logic                in_valid_ff;
   uart_rx_req_type     in_item_ff;
   logic                out_valid_ff;
   uart_rx_rsp_type     out_item_ff, out_item_in;
   logic                advance;
   logic                pop_ok;
   logic                overflow;
   logic [CNT_W-1:0]    fill_count;
   logic [DATA_BITS-1:0] rd_data;
   uart_rx_frm_type     frm;

   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         bit_period_ff <= PERIOD_RESET;
         in_valid_ff   <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         if (csr_write) begin
            bit_period_ff <= csr_data;
         end
         if (!req_stall) begin
            in_valid_ff <= req_valid;
         end
         if (advance) begin
            out_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall && req_valid) begin
         in_item_ff <= req_payload;
      end
      if (advance) begin
         out_item_ff <= out_item_in;
      end
   end

   uart_rx_framer u_framer (
      .clock      (clock),
      .reset      (reset),
      .step       (advance),
      .rx_level   (in_item_ff.rx_level),
      .bit_period (bit_period_ff),
      .frm        (frm)
   );

   uart_rx_fifo_top u_fifo (
      .clock       (clock),
      .reset       (reset),
      .step        (advance),
      .pop_request (in_item_ff.pop_request),
      .frm         (frm),
      .pop_ok      (pop_ok),
      .overflow    (overflow),
      .fill_count  (fill_count),
      .rd_data     (rd_data)
   );

   always_comb begin
      out_item_in                 = '0;
      out_item_in.pop_valid       = pop_ok;
      out_item_in.bytes_available = fill_count;
      out_item_in.overflow        = overflow;
      out_item_in.receiving       = frm.busy;
   end

   // popped byte is picked up from the RAM read register, which holds while stalled
   always_comb begin
      rsp_payload          = out_item_ff;
      rsp_payload.pop_byte = out_item_ff.pop_valid ? rd_data : '0;
   end

   assign rsp_valid = out_valid_ff;

endmodule

>>> design/uart_rx_ram.sv
module uart_rx_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // read-first: a read of the address being written returns the old entry
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> design/uart_rx_framer.sv
module uart_rx_framer import uart_rx_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                step,
   input  logic                rx_level,
   input  logic [PERIOD_W-1:0] bit_period,
   output uart_rx_frm_type     frm
);

   typedef enum logic [1:0] {PH_IDLE, PH_START, PH_DATA, PH_STOP} phase_type;

   phase_type            phase_ff, phase_in;
   logic [PERIOD_W-1:0]  tick_ff, tick_in;
   logic [IDX_W-1:0]     idx_ff, idx_in;
   logic [DATA_BITS-1:0] shift_ff, shift_in;
   logic [PERIOD_W:0]    next_cnt;
   logic [PERIOD_W:0]    half_cnt;
   logic [PERIOD_W:0]    full_cnt;
   logic [DATA_BITS-1:0] sampled;
   logic                 have_byte;

   always_comb begin
      next_cnt  = {1'b0, tick_ff} + (PERIOD_W+1)'(1);
      half_cnt  = {2'b00, bit_period[PERIOD_W-1:1]};
      full_cnt  = {1'b0, bit_period};
      sampled   = shift_ff | (DATA_BITS'(rx_level) << idx_ff);
      phase_in  = phase_ff;
      tick_in   = tick_ff;
      idx_in    = idx_ff;
      shift_in  = shift_ff;
      have_byte = 1'b0;
      if (step) begin
         case (phase_ff)
            PH_IDLE: begin
               if (!rx_level) begin
                  phase_in = PH_START;
                  tick_in  = '0;
               end
            end
            PH_START: begin
               if (next_cnt >= half_cnt) begin
                  phase_in = PH_DATA;
                  tick_in  = '0;
                  idx_in   = '0;
                  shift_in = '0;
               end else begin
                  tick_in = next_cnt[PERIOD_W-1:0];
               end
            end
            PH_DATA: begin
               if (next_cnt >= full_cnt) begin
                  tick_in  = '0;
                  shift_in = sampled;
                  if (idx_ff == IDX_W'(DATA_BITS - 1)) begin
                     have_byte = 1'b1;
                     phase_in  = PH_STOP;
                     idx_in    = '0;
                  end else begin
                     idx_in = idx_ff + IDX_W'(1);
                  end
               end else begin
                  tick_in = next_cnt[PERIOD_W-1:0];
               end
            end
            PH_STOP: begin
               if (next_cnt >= full_cnt) begin
                  phase_in = PH_IDLE;
                  tick_in  = '0;
               end else begin
                  tick_in = next_cnt[PERIOD_W-1:0];
               end
            end
            default: begin
               phase_in = PH_IDLE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         tick_ff  <= '0;
         idx_ff   <= '0;
         shift_ff <= '0;
      end else begin
         phase_ff <= phase_in;
         tick_ff  <= tick_in;
         idx_ff   <= idx_in;
         shift_ff <= shift_in;
      end
   end

   assign frm.have_byte = have_byte;
   assign frm.new_byte  = sampled;
   assign frm.busy      = (phase_in != PH_IDLE);

endmodule

>>> design/uart_rx_fifo_top.sv
module uart_rx_fifo_top import uart_rx_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                step,
   input  logic                pop_request,
   input  uart_rx_frm_type     frm,
   output logic                pop_ok,
   output logic                overflow,
   output logic [CNT_W-1:0]    fill_count,
   output logic [DATA_BITS-1:0] rd_data
);

   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] fill_ff, fill_in;
   logic [CNT_W-1:0] fill_after_pop;
   logic             push_ok;

   always_comb begin
      pop_ok         = step && pop_request && (fill_ff != '0);
      fill_after_pop = fill_ff - CNT_W'(pop_ok);
      push_ok        = step && frm.have_byte && (fill_after_pop != CNT_W'(FIFO_DEPTH));
      overflow       = step && frm.have_byte && !push_ok;
      fill_in        = fill_after_pop + CNT_W'(push_ok);
      rd_ptr_in      = rd_ptr_ff;
      wr_ptr_in      = wr_ptr_ff;
      if (pop_ok) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push_ok) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   assign fill_count = fill_in;

   uart_rx_ram #(
      .WIDTH (DATA_BITS),
      .DEPTH (FIFO_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (push_ok),
      .wr_addr (wr_ptr_ff),
      .wr_data (frm.new_byte),
      .rd_en   (pop_ok),
      .rd_addr (rd_ptr_ff),
      .rd_data (rd_data)
   );

endmodule
